// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int VALUE_BITS    = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int CNT_BITS      = $clog2(CAPACITY + 1);

  localparam int CMD_BITS = 2;
  localparam logic [CMD_BITS-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_EXTRACT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_PEEK    = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd3;

  localparam int IN_BITS    = VALUE_BITS + PRIORITY_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = VALUE_BITS + PRIORITY_BITS + CNT_BITS + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [VALUE_BITS-1:0]    value_t;
  typedef logic signed [PRIORITY_BITS-1:0] prio_t;

  // Per-cycle operation broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic ext;
  } spq_ctrl_t;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  spq_ctrl_t ctrl_i,
  input  logic      occ_i,
  input  value_t    new_value_i,
  input  prio_t     new_prio_i,
  input  logic      left_before_i,
  input  value_t    left_value_i,
  input  prio_t     left_prio_i,
  input  value_t    right_value_i,
  input  prio_t     right_prio_i,
  output logic      before_o,
  output value_t    value_o,
  output prio_t     prio_o
);

  value_t value_q, value_d;
  prio_t  prio_q,  prio_d;

  // New item lands ahead of this cell on strictly smaller priority, so ties stay in order.
  assign before_o = !occ_i || (new_prio_i < prio_q);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.ins) begin
      if (left_before_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else if (before_o) begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (ctrl_i.ext) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ===== hdl/stable_min_priority_queue_unit.sv =====
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   value_in, priority_in                       cmd
// m_axis    out  value_out, priority_out, count, is_empty    ok
//
// One item per cycle unless the output stalls: every command finishes in the
// cycle it is accepted, as the whole cell chain shifts in a single step; the
// result is held in the output register from the following cycle.
// Reset clears the entry count and the output valid flag; cell contents stay.
// An output stall holds the result and stops input only while it is held.
module stable_min_priority_queue_unit
  import spq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value_in, priority_in
  input  logic [CMD_BITS-1:0]    s_axis_tuser,   // cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // value_out, priority_out, count, is_empty
  output logic                   m_axis_tuser    // ok
);

  logic [CNT_BITS-1:0] count_q, count_d;
  logic                out_valid_q;
  logic                ok_q, ok_d;
  value_t              vout_q, vout_d;
  prio_t               pout_q, pout_d;
  logic [CNT_BITS-1:0] cnt_out_q;

  logic      accept;
  logic      full, empty;
  value_t    new_value;
  prio_t     new_prio;
  spq_ctrl_t ctrl;

  logic   [CAPACITY-1:0] occ;
  logic   [CAPACITY-1:0] ahead;
  value_t                cell_value [CAPACITY];
  prio_t                 cell_prio  [CAPACITY];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign new_value     = s_axis_tdata[VALUE_BITS-1:0];
  assign new_prio      = s_axis_tdata[VALUE_BITS +: PRIORITY_BITS];
  assign full          = (count_q == CNT_BITS'(CAPACITY));
  assign empty         = (count_q == '0);

  assign ctrl.ins = accept && (s_axis_tuser == CMD_INSERT) && !full;
  assign ctrl.ext = accept && (s_axis_tuser == CMD_EXTRACT) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_BITS'(i) < count_q);
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .occ_i         (occ[i]),
        .new_value_i   (new_value),
        .new_prio_i    (new_prio),
        .left_before_i (1'b0),
        .left_value_i  (cell_value[i]),
        .left_prio_i   (cell_prio[i]),
        .right_value_i (cell_value[i+1]),
        .right_prio_i  (cell_prio[i+1]),
        .before_o      (ahead[i]),
        .value_o       (cell_value[i]),
        .prio_o        (cell_prio[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      spq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .occ_i         (occ[i]),
        .new_value_i   (new_value),
        .new_prio_i    (new_prio),
        .left_before_i (ahead[i-1]),
        .left_value_i  (cell_value[i-1]),
        .left_prio_i   (cell_prio[i-1]),
        .right_value_i (cell_value[i]),
        .right_prio_i  (cell_prio[i]),
        .before_o      (ahead[i]),
        .value_o       (cell_value[i]),
        .prio_o        (cell_prio[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .occ_i         (occ[i]),
        .new_value_i   (new_value),
        .new_prio_i    (new_prio),
        .left_before_i (ahead[i-1]),
        .left_value_i  (cell_value[i-1]),
        .left_prio_i   (cell_prio[i-1]),
        .right_value_i (cell_value[i+1]),
        .right_prio_i  (cell_prio[i+1]),
        .before_o      (ahead[i]),
        .value_o       (cell_value[i]),
        .prio_o        (cell_prio[i])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    ok_d    = 1'b0;
    vout_d  = '0;
    pout_d  = '0;
    case (s_axis_tuser)
      CMD_INSERT: begin
        if (!full) begin
          count_d = count_q + CNT_BITS'(1);
          ok_d    = 1'b1;
        end
      end
      CMD_EXTRACT, CMD_PEEK: begin
        if (!empty) begin
          ok_d   = 1'b1;
          vout_d = cell_value[0];
          pout_d = cell_prio[0];
          if (s_axis_tuser == CMD_EXTRACT) begin
            count_d = count_q - CNT_BITS'(1);
          end
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
        ok_d    = 1'b1;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until taken; load a fresh one on each accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      vout_q    <= vout_d;
      pout_q    <= pout_d;
      cnt_out_q <= count_d;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[VALUE_BITS-1:0]                            = vout_q;
    m_axis_tdata[VALUE_BITS +: PRIORITY_BITS]               = pout_q;
    m_axis_tdata[VALUE_BITS + PRIORITY_BITS +: CNT_BITS]    = cnt_out_q;
    m_axis_tdata[VALUE_BITS + PRIORITY_BITS + CNT_BITS]     = (cnt_out_q == '0);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = ok_q;

endmodule

// ===== verif/tb_stable_min_priority_queue_unit.sv =====
`timescale 1ns / 1ps

module tb_stable_min_priority_queue_unit;
  import spq_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int STALL_CYCLES = 80;
  localparam int WATCHDOG_MAX = 1000;

  typedef struct packed {
    logic                ok;
    value_t              v;
    prio_t               p;
    logic [CNT_BITS-1:0] cnt;
    logic                empty;
  } result_t;

  typedef struct {
    value_t v;
    prio_t  p;
  } entry_t;

  typedef struct {
    logic [CMD_BITS-1:0] cmd;
    value_t              v;
    prio_t               p;
    int                  reps;
    bit                  has_exp;
    result_t             e;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // value_in, priority_in
  logic [CMD_BITS-1:0]    s_axis_tuser;   // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // value_out, priority_out, count, is_empty
  logic                   m_axis_tuser;   // ok

  entry_t   held_q[$];          // entries held, oldest first
  result_t  pending_results[$];
  dir_row_t dir_rows[$];

  bit      row_has_exp;
  result_t row_exp;
  int      stall_reqs;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      idle_cycles;
  int      err_count;
  int      n_insert, n_refused, n_extract, n_peek, n_clear, n_miss, n_checked;

  stable_min_priority_queue_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Apply one command to the shadow queue and return its result.
  function automatic result_t serve_cmd(logic [CMD_BITS-1:0] c, value_t v, prio_t p);
    result_t r;
    int      best;
    r = '0;
    case (c)
      CMD_INSERT: begin
        if (held_q.size() < CAPACITY) begin
          held_q.push_back('{v: v, p: p});
          r.ok = 1'b1;
          n_insert++;
        end else begin
          n_refused++;
        end
      end
      CMD_EXTRACT, CMD_PEEK: begin
        if (held_q.size() > 0) begin
          best = 0;
          // strict less keeps the oldest entry on ties
          for (int k = 1; k < held_q.size(); k++)
            if ($signed(held_q[k].p) < $signed(held_q[best].p)) best = k;
          r.ok = 1'b1;
          r.v  = held_q[best].v;
          r.p  = held_q[best].p;
          if (c == CMD_EXTRACT) held_q.delete(best);
        end else begin
          n_miss++;
        end
        if (c == CMD_EXTRACT) n_extract++;
        else n_peek++;
      end
      default: begin
        held_q.delete();
        r.ok = 1'b1;
        n_clear++;
      end
    endcase
    r.cnt   = CNT_BITS'(held_q.size());
    r.empty = (held_q.size() == 0);
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok    = m_axis_tuser;
        got.v     = m_axis_tdata[VALUE_BITS-1:0];
        got.p     = m_axis_tdata[VALUE_BITS +: PRIORITY_BITS];
        got.cnt   = m_axis_tdata[VALUE_BITS+PRIORITY_BITS +: CNT_BITS];
        got.empty = m_axis_tdata[OUT_BITS-1];
        if (pending_results.size() == 0) begin
          $error("result with no command outstanding");
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("value_out", want.v, got.v);
          check_field("priority_out", want.p, got.p);
          check_field("count", want.cnt, got.cnt);
          check_field("is_empty", want.empty, got.empty);
          n_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = serve_cmd(s_axis_tuser, s_axis_tdata[VALUE_BITS-1:0],
                         s_axis_tdata[VALUE_BITS +: PRIORITY_BITS]);
        pending_results.push_back(row_has_exp ? row_exp : want);
      end
    end
  end

  // Abort when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int stalls_done;
    stalls_done   = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_reqs != stalls_done) begin
        m_axis_tready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
        stalls_done++;
      end
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_row(logic [CMD_BITS-1:0] c, value_t v, prio_t p, int reps, int has_exp,
                         int e_ok, value_t e_v, prio_t e_p, int e_cnt, int e_empty);
    dir_row_t row;
    row.cmd     = c;
    row.v       = v;
    row.p       = p;
    row.reps    = reps;
    row.has_exp = has_exp[0];
    row.e       = '{ok: e_ok[0], v: e_v, p: e_p, cnt: e_cnt[CNT_BITS-1:0], empty: e_empty[0]};
    dir_rows.push_back(row);
  endtask

  // Offer one item, starting and ending at a falling edge.
  task automatic offer(logic [CMD_BITS-1:0] c, value_t v, prio_t p, bit has_exp, result_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c;
    s_axis_tdata  = {p, v};
    row_has_exp   = has_exp;
    row_exp       = e;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_random(int n);
    logic [CMD_BITS-1:0] c;
    bit                  fill_bias;
    bit                  tie_mode;
    int                  r;
    prio_t               p;
    for (int i = 0; i < n; i++) begin
      // switch between filling and draining runs so both full and empty are hit often
      if (i % 32 == 0) begin
        fill_bias = 1'($urandom_range(1));
        tie_mode  = ($urandom_range(3) == 0);
      end
      r = $urandom_range(99);
      if (fill_bias)
        c = (r < 70) ? CMD_INSERT : (r < 85) ? CMD_EXTRACT : (r < 97) ? CMD_PEEK : CMD_CLEAR;
      else
        c = (r < 35) ? CMD_INSERT : (r < 80) ? CMD_EXTRACT : (r < 97) ? CMD_PEEK : CMD_CLEAR;
      p = tie_mode ? prio_t'($urandom_range(3)) - prio_t'(2) : prio_t'($urandom);
      offer(c, value_t'($urandom), p, 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_INSERT;
    row_has_exp   = 1'b0;
    row_exp       = '0;
    stall_reqs    = 0;
    send_idle_pct = 10;
    recv_idle_pct = 63;

    add_row(CMD_PEEK,    32'sh0,         16'sh0,    1, 1, 0, 32'sh0,         16'sh0,    0, 1);
    add_row(CMD_EXTRACT, 32'sh0,         16'sh0,    1, 1, 0, 32'sh0,         16'sh0,    0, 1);
    add_row(CMD_INSERT,  32'sh7FFF_FFFF, 16'sh7FFF, 1, 1, 1, 32'sh0,         16'sh0,    1, 0);
    add_row(CMD_INSERT,  32'sh8000_0000, 16'sh8000, 1, 1, 1, 32'sh0,         16'sh0,    2, 0);
    add_row(CMD_INSERT,  32'shFFFF_FFFF, 16'sh8000, 1, 1, 1, 32'sh0,         16'sh0,    3, 0);
    add_row(CMD_PEEK,    32'sh0,         16'sh0,    1, 1, 1, 32'sh8000_0000, 16'sh8000, 3, 0);
    add_row(CMD_EXTRACT, 32'sh0,         16'sh0,    1, 1, 1, 32'sh8000_0000, 16'sh8000, 2, 0);
    add_row(CMD_EXTRACT, 32'sh0,         16'sh0,    1, 1, 1, 32'shFFFF_FFFF, 16'sh8000, 1, 0);
    add_row(CMD_EXTRACT, 32'sh0,         16'sh0,    1, 1, 1, 32'sh7FFF_FFFF, 16'sh7FFF, 0, 1);
    // equal priorities up to full, then a refused insert and a peek for the oldest
    add_row(CMD_INSERT,  32'sh100,       16'sh3,   16, 0, 0, 32'sh0,         16'sh0,    0, 0);
    add_row(CMD_INSERT,  32'sh5555_5555, 16'sh8000, 1, 1, 0, 32'sh0,         16'sh0,   16, 0);
    add_row(CMD_PEEK,    32'shAAAA_AAAA, 16'sh5555, 1, 0, 0, 32'sh0,         16'sh0,    0, 0);
    add_row(CMD_CLEAR,   32'sh0,         16'sh0,    1, 1, 1, 32'sh0,         16'sh0,    0, 1);
    add_row(CMD_PEEK,    32'sh0,         16'sh0,    1, 1, 0, 32'sh0,         16'sh0,    0, 1);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      for (int k = 0; k < dir_rows[i].reps; k++)
        offer(dir_rows[i].cmd, dir_rows[i].v + value_t'(k), dir_rows[i].p,
              dir_rows[i].has_exp, dir_rows[i].e);

    // long output stall while items keep coming, so the input backs up
    stall_reqs++;
    run_random(40);
    settle();
    run_random(400);
    settle();

    send_idle_pct = 63;
    recv_idle_pct = 10;
    run_random(430);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(430);
    settle();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d inserts (%0d refused when full), %0d extracts, %0d peeks, %0d clears",
             n_insert, n_refused, n_extract, n_peek, n_clear);
    $display("%0d commands hit an empty queue; %0d results checked", n_miss, n_checked);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
